### hw/rtl/cfe_pkg.sv
// Shared types and codes for the four-register execute unit.
// No dependencies; imported by cfe_dmem, cfe_core and the top level.
package cfe_pkg;

    // Default data memory depth, and the widest memory address that any depth needs
    localparam int MEM_WORDS_DEF = 32;
    localparam int MEM_ADDR_W    = 6;

    // Instruction and host command codes
    localparam logic [3:0] CMD_NOP     = 4'd0;
    localparam logic [3:0] CMD_LOAD    = 4'd1;
    localparam logic [3:0] CMD_STORE   = 4'd2;
    localparam logic [3:0] CMD_MOVE    = 4'd3;
    localparam logic [3:0] CMD_ADD     = 4'd4;
    localparam logic [3:0] CMD_SUB     = 4'd5;
    localparam logic [3:0] CMD_AND     = 4'd6;
    localparam logic [3:0] CMD_OR      = 4'd7;
    localparam logic [3:0] CMD_BRANCH  = 4'd8;
    localparam logic [3:0] CMD_BZERO   = 4'd9;
    localparam logic [3:0] CMD_BNEG    = 4'd10;
    localparam logic [3:0] CMD_HALT    = 4'd11;
    localparam logic [3:0] CMD_POKE    = 4'd12;
    localparam logic [3:0] CMD_PEEKMEM = 4'd13;
    localparam logic [3:0] CMD_PEEKREG = 4'd14;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BADADDR = 2'd1;
    localparam logic [1:0] ST_STOPPED = 2'd2;

    // One decoded instruction as held in the input register
    typedef struct packed {
        logic [3:0]         cmd;
        logic [1:0]         dest_reg;
        logic [1:0]         src_a;
        logic [1:0]         src_b;
        logic [6:0]         address;
        logic signed [31:0] data;
    } t_item;

    // One result item
    typedef struct packed {
        logic signed [31:0] result_value;
        logic [5:0]         next_pc;
        logic               branch_taken;
        logic [1:0]         status;
        logic               halted;
    } t_result;

    // Data memory write request from the execute logic
    typedef struct packed {
        logic                  en;
        logic [MEM_ADDR_W-1:0] addr;
        logic [31:0]           data;
    } t_mem_wr;

endpackage

### hw/rtl/four_register_cpu_execute_top.sv
// Top level of the four-register execute unit: input register, handshake
// and output register. Depends on cfe_pkg, cfe_dmem and cfe_core.
//
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one decoded instruction or
//   host command per item (i_cmd, i_dest_reg, i_src_a, i_src_b, i_address,
//   i_data). Output channel: o_out_valid / i_out_stall carry one result per
//   item (value, next pc, branch taken, status, halted).
//   An item passes the input register, then the output register, before
//   its result appears. Throughput: one item per cycle while the receiver
//   is not stalling; the input register, the data memory read port and the
//   execute logic each handle one item a cycle. The memory word is read as
//   the item is accepted, and a write by the item ahead of it is forwarded.
//   Reset (synchronous, active low) clears the registers, pc, stop flag and
//   the memory valid bits at once; unwritten words read as zero, so no
//   clearing pass is needed and items are taken right after reset.
//   When the receiver stalls, the result is held in the output register
//   and one more item waits in the input register; only then is the input
//   stalled.
module four_register_cpu_execute_top #(
    parameter int MEM_WORDS = cfe_pkg::MEM_WORDS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [3:0]         i_cmd,
    input  logic [1:0]         i_dest_reg,
    input  logic [1:0]         i_src_a,
    input  logic [1:0]         i_src_b,
    input  logic [6:0]         i_address,
    input  logic signed [31:0] i_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_result_value,
    output logic [5:0]         o_next_pc,
    output logic               o_branch_taken,
    output logic [1:0]         o_status,
    output logic               o_halted
);
    import cfe_pkg::*;

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_result;
    logic    accept;
    logic    exec_fire;
    t_result exec_result;
    t_mem_wr mem_wr;
    logic [31:0] mem_rdata;

    // pipeline control
    assign exec_fire  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !exec_fire;
    assign accept     = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (exec_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.cmd      <= i_cmd;
            r_item.dest_reg <= i_dest_reg;
            r_item.src_a    <= i_src_a;
            r_item.src_b    <= i_src_b;
            r_item.address  <= i_address;
            r_item.data     <= i_data;
        end
    end

    cfe_dmem #(
        .MEM_WORDS (MEM_WORDS)
    ) u_dmem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (i_address),
        .i_wr      (mem_wr),
        .o_rd_data (mem_rdata)
    );

    cfe_core #(
        .MEM_WORDS (MEM_WORDS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (exec_fire),
        .i_item      (r_item),
        .i_mem_rdata (mem_rdata),
        .o_result    (exec_result),
        .o_mem_wr    (mem_wr)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_fire) begin
            r_result <= exec_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_result.result_value;
    assign o_next_pc      = r_result.next_pc;
    assign o_branch_taken = r_result.branch_taken;
    assign o_status       = r_result.status;
    assign o_halted       = r_result.halted;

    // every executed item lands in the output register
    a_exec_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec_fire |=> r_out_valid)
        else $error("executed item did not reach the output register");

    // an accepted item is held for execution
    a_accept_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_in_valid)
        else $error("accepted item lost from the input register");

    // a waiting result is never overwritten while the receiver stalls
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !exec_fire)
        else $error("result overwritten under stall");

endmodule

### hw/rtl/cfe_dmem.sv
// Data memory with per-word valid bits (unwritten words read as zero) and
// registered read with write-to-read forwarding. Depends on cfe_pkg.
module cfe_dmem #(
    parameter int MEM_WORDS = cfe_pkg::MEM_WORDS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [6:0]       i_rd_addr,
    input  cfe_pkg::t_mem_wr i_wr,
    output logic [31:0]      o_rd_data
);
    import cfe_pkg::*;

    localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

    logic [31:0]          mem [MEM_WORDS];
    logic [MEM_WORDS-1:0] r_valid;
    logic [31:0]          r_rd_data;
    logic [AW-1:0]        wr_idx;
    logic [AW-1:0]        rd_idx;
    logic                 fwd;

    assign wr_idx = i_wr.addr[AW-1:0];
    assign rd_idx = i_rd_addr[AW-1:0];
    // same word written at this edge: take the new data
    assign fwd    = i_wr.en && (i_wr.addr == i_rd_addr[MEM_ADDR_W-1:0])
                    && !i_rd_addr[6];

    // storage array
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[wr_idx] <= i_wr.data;
        end
    end

    // valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[wr_idx] <= 1'b1;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (fwd) begin
                r_rd_data <= i_wr.data;
            end else if (r_valid[rd_idx]) begin
                r_rd_data <= mem[rd_idx];
            end else begin
                r_rd_data <= '0;
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/cfe_core.sv
// Execute logic: register file, program counter and stop flag, plus the
// single-pass decode/ALU/branch logic. Depends on cfe_pkg.
module cfe_core #(
    parameter int MEM_WORDS = cfe_pkg::MEM_WORDS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  cfe_pkg::t_item    i_item,
    input  logic [31:0]       i_mem_rdata,
    output cfe_pkg::t_result  o_result,
    output cfe_pkg::t_mem_wr  o_mem_wr
);
    import cfe_pkg::*;

    localparam logic [6:0] MemWordsV = 7'(MEM_WORDS);

    logic [31:0] r_regs [4];
    logic [31:0] n_regs [4];
    logic [5:0]  r_pc;
    logic [5:0]  n_pc;
    logic        r_stopped;
    logic        n_stopped;

    logic        addr_ok;
    logic        is_host;
    logic        needs_addr;
    logic        advance;
    logic        taken;
    logic [6:0]  pc_inc;
    logic [31:0] value;
    logic [1:0]  status;
    logic [31:0] opa;
    logic [31:0] opb;
    t_mem_wr     mem_wr;

    assign addr_ok    = i_item.address < MemWordsV;
    assign is_host    = i_item.cmd inside {CMD_POKE, CMD_PEEKMEM, CMD_PEEKREG};
    assign needs_addr = i_item.cmd inside {CMD_LOAD, CMD_STORE, CMD_BRANCH,
                                           CMD_BZERO, CMD_BNEG};
    assign opa        = r_regs[i_item.src_a];
    assign opb        = r_regs[i_item.src_b];
    assign pc_inc     = {1'b0, r_pc} + 7'd1;

    // decode and execute one item
    always_comb begin
        n_regs    = r_regs;
        n_pc      = r_pc;
        n_stopped = r_stopped;
        value     = '0;
        status    = ST_OK;
        taken     = 1'b0;
        advance   = 1'b0;
        mem_wr    = '0;
        mem_wr.addr = i_item.address[MEM_ADDR_W-1:0];

        if (is_host) begin
            // host access works even when stopped
            if (i_item.cmd == CMD_PEEKREG) begin
                value = r_regs[i_item.dest_reg];
            end else if (!addr_ok) begin
                status = ST_BADADDR;
            end else if (i_item.cmd == CMD_POKE) begin
                mem_wr.en   = 1'b1;
                mem_wr.data = i_item.data;
            end else begin
                value = i_mem_rdata;
            end
        end else if (r_stopped) begin
            status = ST_STOPPED;
        end else if (needs_addr && !addr_ok) begin
            status    = ST_BADADDR;
            n_stopped = 1'b1;
        end else begin
            advance = 1'b1;
            unique case (i_item.cmd)
                CMD_LOAD: begin
                    value = i_mem_rdata;
                    n_regs[i_item.dest_reg] = value;
                end
                CMD_STORE: begin
                    mem_wr.en   = 1'b1;
                    mem_wr.data = opa;
                end
                CMD_MOVE: begin
                    value = opa;
                    n_regs[i_item.dest_reg] = value;
                end
                CMD_ADD: begin
                    value = opa + opb;
                    n_regs[i_item.dest_reg] = value;
                end
                CMD_SUB: begin
                    value = opa - opb;
                    n_regs[i_item.dest_reg] = value;
                end
                CMD_AND: begin
                    value = opa & opb;
                    n_regs[i_item.dest_reg] = value;
                end
                CMD_OR: begin
                    value = opa | opb;
                    n_regs[i_item.dest_reg] = value;
                end
                CMD_BRANCH: taken = 1'b1;
                CMD_BZERO:  taken = (r_regs[0] == 32'd0);
                CMD_BNEG:   taken = r_regs[0][31];
                CMD_HALT: begin
                    n_stopped = 1'b1;
                    advance   = 1'b0;
                end
                default: ;
            endcase
            if (taken) begin
                n_pc    = i_item.address[5:0];
                advance = 1'b0;
            end
            // sequential flow; running off the end of memory stops the block
            if (advance) begin
                n_pc = pc_inc[5:0];
                if (pc_inc >= MemWordsV) begin
                    n_stopped = 1'b1;
                end
            end
        end
    end

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs    <= '{default: '0};
            r_pc      <= '0;
            r_stopped <= 1'b0;
        end else if (i_fire) begin
            r_regs    <= n_regs;
            r_pc      <= n_pc;
            r_stopped <= n_stopped;
        end
    end

    assign o_result.result_value = value;
    assign o_result.next_pc      = n_pc;
    assign o_result.branch_taken = taken;
    assign o_result.status       = status;
    assign o_result.halted       = n_stopped;

    assign o_mem_wr.en   = mem_wr.en && i_fire;
    assign o_mem_wr.addr = mem_wr.addr;
    assign o_mem_wr.data = mem_wr.data;

    // once stopped, only reset restarts the block
    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |=> r_stopped)
        else $error("stop flag cleared without reset");

    // a running block never holds a pc at or past the end of memory
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_stopped |-> ({1'b0, r_pc} < MemWordsV))
        else $error("pc out of range while running");

    // an ignored instruction keeps the pc and takes no branch
    a_stopped_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && status == ST_STOPPED) |=> ($stable(r_pc) && !$past(taken)))
        else $error("instruction changed pc while stopped");

endmodule
